/* rtl/hcsd_pkg.sv */
// Package for the HTTP chunked stream decoder.
// Holds the phase, kind and error codes, the line flag type and the hex decode.
// No dependencies.
package hcsd_pkg;

  localparam int unsigned SIZE_WIDTH_DEFAULT = 32;

  localparam logic [7:0] CHAR_SEMI = 8'h3B;
  localparam logic [7:0] CHAR_CR   = 8'h0D;
  localparam logic [7:0] CHAR_LF   = 8'h0A;
  localparam int unsigned DIGIT_BITS = 4;

  typedef enum logic [7:0] {
    PH_SIZE    = 8'b0000_0001,
    PH_PAYLOAD = 8'b0000_0010,
    PH_DATA_CR = 8'b0000_0100,
    PH_DATA_LF = 8'b0000_1000,
    PH_FIN_CR  = 8'b0001_0000,
    PH_FIN_LF  = 8'b0010_0000,
    PH_DONE    = 8'b0100_0000,
    PH_ERROR   = 8'b1000_0000
  } phase_t;

  typedef enum logic [1:0] {
    K_FRAME   = 2'd0,
    K_PAYLOAD = 2'd1,
    K_DONE    = 2'd2,
    K_ERROR   = 2'd3
  } kind_t;

  typedef enum logic [2:0] {
    E_NONE      = 3'd0,
    E_DATA_CRLF = 3'd1,
    E_FIN_CRLF  = 3'd2,
    E_MALFORMED = 3'd3,
    E_NON_HEX   = 3'd4,
    E_EMPTY     = 3'd5,
    E_OVERFLOW  = 3'd6
  } err_t;

  typedef struct packed {
    logic semi;
    logic digit;
    logic badhex;
    logic ovf;
    logic cr;
  } line_flags_t;

  typedef struct packed {
    logic       valid;
    logic [3:0] value;
  } hex_digit_t;

  function automatic hex_digit_t hex_decode(input logic [7:0] c);
    hex_digit_t d;
    d.valid = 1'b1;
    d.value = 4'd0;
    if (c >= 8'h30 && c <= 8'h39) begin
      d.value = 4'(c - 8'h30);
    end else if (c >= 8'h61 && c <= 8'h66) begin
      d.value = 4'(c - 8'h57);
    end else if (c >= 8'h41 && c <= 8'h46) begin
      d.value = 4'(c - 8'h37);
    end else begin
      d.valid = 1'b0;
    end
    return d;
  endfunction

endpackage

/* rtl/hcsd_in_if.sv */
// Input channel of the chunked stream decoder: one wire byte per word.
// Depends on nothing.
interface hcsd_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] wire_byte;

  modport source (output valid, output wire_byte, input ready);
  modport sink (input valid, input wire_byte, output ready);
endinterface

/* rtl/hcsd_out_if.sv */
// Result channel of the chunked stream decoder: one decode result per word.
// Depends on hcsd_pkg for the kind and error code types.
interface hcsd_out_if;
  logic          valid;
  logic          ready;
  hcsd_pkg::kind_t kind;
  logic [7:0]    payload_byte;
  logic          chunk_end;
  hcsd_pkg::err_t  error_code;

  modport source (output valid, output kind, output payload_byte, output chunk_end,
                  output error_code, input ready);
  modport sink (input valid, input kind, input payload_byte, input chunk_end,
                input error_code, output ready);
endinterface

/* rtl/http_chunked_stream_decoder_core.sv */
// Top level of the HTTP/1.1 chunked transfer decoder.
// Depends on hcsd_pkg, hcsd_in_if and hcsd_out_if.
//
// The decoder takes one body byte per word and returns exactly one result word for it:
// framing, payload (with the last byte of each chunk marked), stream complete, or error.
// It accepts a byte in every clock cycle; each byte is decoded in the cycle it is
// accepted and its result sits in the output register in the following cycle. The only limit
// on rate is the output register: a new byte is taken whenever that register is empty
// or is being read in the same cycle. Errors and the complete indication are sticky
// until reset. Chunk sizes wider than SIZE_WIDTH bits are reported as overflow.
module http_chunked_stream_decoder_core #(
  parameter int unsigned SIZE_WIDTH = hcsd_pkg::SIZE_WIDTH_DEFAULT
) (
  input logic        clk,
  input logic        rst,
  hcsd_in_if.sink    rx,
  hcsd_out_if.source tx
);
  import hcsd_pkg::*;

  phase_t                phase, phase_next;
  logic [SIZE_WIDTH-1:0] chunk_remaining, chunk_remaining_next;
  logic [SIZE_WIDTH-1:0] size_acc, size_acc_next;
  line_flags_t           line_flags, line_flags_next;
  err_t                  sticky_error, sticky_error_next;

  kind_t      res_kind;
  logic [7:0] res_payload;
  logic       res_chunk_end;
  err_t       res_error;

  hex_digit_t            digit;
  logic                  accept;
  logic [SIZE_WIDTH-1:0] remaining_dec;

  assign rx.ready      = !tx.valid || tx.ready;
  assign accept        = rx.valid && rx.ready;
  assign digit         = hex_decode(rx.wire_byte);
  assign remaining_dec = chunk_remaining - SIZE_WIDTH'(1);

  always_comb begin
    phase_next           = phase;
    chunk_remaining_next = chunk_remaining;
    size_acc_next        = size_acc;
    line_flags_next      = line_flags;
    sticky_error_next    = sticky_error;
    res_kind             = K_FRAME;
    res_payload          = 8'd0;
    res_chunk_end        = 1'b0;
    case (phase)
      PH_SIZE: begin
        if (rx.wire_byte == CHAR_LF) begin
          if (!line_flags.cr) begin
            sticky_error_next = E_MALFORMED;
          end else if (line_flags.badhex) begin
            sticky_error_next = E_NON_HEX;
          end else if (!line_flags.digit) begin
            sticky_error_next = E_EMPTY;
          end else if (line_flags.ovf) begin
            sticky_error_next = E_OVERFLOW;
          end
          if (!line_flags.cr || line_flags.badhex || !line_flags.digit || line_flags.ovf) begin
            phase_next = PH_ERROR;
            res_kind   = K_ERROR;
          end else if (size_acc == '0) begin
            phase_next = PH_FIN_CR;
          end else begin
            chunk_remaining_next = size_acc;
            phase_next           = PH_PAYLOAD;
          end
          size_acc_next   = '0;
          line_flags_next = '0;
        end else begin
          // A CR that was not followed by LF is an ordinary line byte.
          if (line_flags.cr && !line_flags.semi) begin
            line_flags_next.badhex = 1'b1;
          end
          if (rx.wire_byte == CHAR_CR) begin
            line_flags_next.cr = 1'b1;
          end else begin
            line_flags_next.cr = 1'b0;
            if (!line_flags_next.semi) begin
              if (rx.wire_byte == CHAR_SEMI) begin
                line_flags_next.semi = 1'b1;
              end else if (!line_flags_next.badhex) begin
                if (digit.valid) begin
                  if (size_acc[SIZE_WIDTH-1 -: DIGIT_BITS] != '0) begin
                    line_flags_next.ovf = 1'b1;
                  end
                  size_acc_next         = {size_acc[SIZE_WIDTH-DIGIT_BITS-1:0], digit.value};
                  line_flags_next.digit = 1'b1;
                end else begin
                  line_flags_next.badhex = 1'b1;
                end
              end
            end
          end
        end
      end
      PH_PAYLOAD: begin
        res_kind             = K_PAYLOAD;
        res_payload          = rx.wire_byte;
        chunk_remaining_next = remaining_dec;
        if (remaining_dec == '0) begin
          res_chunk_end = 1'b1;
          phase_next    = PH_DATA_CR;
        end
      end
      PH_DATA_CR: begin
        if (rx.wire_byte == CHAR_CR) begin
          phase_next = PH_DATA_LF;
        end else begin
          phase_next        = PH_ERROR;
          sticky_error_next = E_DATA_CRLF;
          res_kind          = K_ERROR;
        end
      end
      PH_DATA_LF: begin
        if (rx.wire_byte == CHAR_LF) begin
          phase_next = PH_SIZE;
        end else begin
          phase_next        = PH_ERROR;
          sticky_error_next = E_DATA_CRLF;
          res_kind          = K_ERROR;
        end
      end
      PH_FIN_CR: begin
        if (rx.wire_byte == CHAR_CR) begin
          phase_next = PH_FIN_LF;
        end else begin
          phase_next        = PH_ERROR;
          sticky_error_next = E_FIN_CRLF;
          res_kind          = K_ERROR;
        end
      end
      PH_FIN_LF: begin
        if (rx.wire_byte == CHAR_LF) begin
          phase_next = PH_DONE;
          res_kind   = K_DONE;
        end else begin
          phase_next        = PH_ERROR;
          sticky_error_next = E_FIN_CRLF;
          res_kind          = K_ERROR;
        end
      end
      PH_DONE: begin
        res_kind = K_DONE;
      end
      default: begin
        phase_next = PH_ERROR;
        res_kind   = K_ERROR;
      end
    endcase
    res_error = (res_kind == K_ERROR) ? sticky_error_next : E_NONE;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      phase           <= PH_SIZE;
      chunk_remaining <= '0;
      size_acc        <= '0;
      line_flags      <= '0;
      sticky_error    <= E_NONE;
      tx.valid        <= 1'b0;
    end else begin
      if (accept) begin
        phase           <= phase_next;
        chunk_remaining <= chunk_remaining_next;
        size_acc        <= size_acc_next;
        line_flags      <= line_flags_next;
        sticky_error    <= sticky_error_next;
        tx.valid        <= 1'b1;
      end else if (tx.ready) begin
        tx.valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      tx.kind         <= res_kind;
      tx.payload_byte <= res_payload;
      tx.chunk_end    <= res_chunk_end;
      tx.error_code   <= res_error;
    end
  end

  a_error_sticky: assert property (@(posedge clk) disable iff (rst)
    accept && phase == PH_ERROR |=> tx.valid && tx.kind == K_ERROR && phase == PH_ERROR)
    else $error("error phase left or non-error result after error");

  a_done_sticky: assert property (@(posedge clk) disable iff (rst)
    accept && phase == PH_DONE |=> tx.valid && tx.kind == K_DONE && phase == PH_DONE)
    else $error("done phase left or wrong result after stream end");

  a_chunk_end_phase: assert property (@(posedge clk) disable iff (rst)
    accept && phase == PH_PAYLOAD && chunk_remaining == SIZE_WIDTH'(1)
    |=> tx.chunk_end && phase == PH_DATA_CR)
    else $error("last payload byte not marked or CR LF check not entered");

  a_payload_nonzero: assert property (@(posedge clk) disable iff (rst)
    phase == PH_PAYLOAD |-> chunk_remaining != '0)
    else $error("payload phase with no bytes due");

  a_error_code_kind: assert property (@(posedge clk) disable iff (rst)
    tx.valid && tx.kind != K_ERROR |-> tx.error_code == E_NONE && sticky_error == E_NONE)
    else $error("error code present without an error result");

endmodule

/* tb/tb_http_chunked_stream_decoder_core.sv */
// Self-checking testbench for http_chunked_stream_decoder_core: drives chunked body bytes,
// predicts every decode result in lockstep and compares them field by field.
// Depends on hcsd_pkg, hcsd_in_if, hcsd_out_if and the decoder core.
`timescale 1ns / 100ps

module tb_http_chunked_stream_decoder_core;
  import hcsd_pkg::*;

  localparam int unsigned SW = SIZE_WIDTH_DEFAULT;
  localparam int unsigned CYCLE_LIMIT = 200000;
  localparam int unsigned RANDOM_WORDS = 660;
  localparam int unsigned QUIET_AFTER = 580;

  typedef struct packed {
    kind_t      kind;
    logic [7:0] payload_byte;
    logic       chunk_end;
    err_t       error_code;
  } decode_result_t;

  typedef enum int unsigned {
    END_DONE,
    END_DATA_CR,
    END_DATA_LF,
    END_FIN_CR,
    END_FIN_LF,
    END_MALFORMED,
    END_BARE_LF,
    END_NON_HEX,
    END_EMBEDDED_CR,
    END_EMPTY,
    END_OVERFLOW
  } stream_end_t;

  logic clk;
  logic rst;

  hcsd_in_if  rx_if ();
  hcsd_out_if tx_if ();

  http_chunked_stream_decoder_core #(.SIZE_WIDTH(SW)) dut (
    .clk(clk),
    .rst(rst),
    .rx (rx_if),
    .tx (tx_if)
  );

  phase_t         dec_phase;
  logic [SW-1:0]  bytes_due;
  logic [SW-1:0]  size_acc;
  line_flags_t    flags;
  err_t           held_err;
  decode_result_t expected_results[$];

  int unsigned mismatches = 0;
  int unsigned words_sent;
  int unsigned chunks_sent;
  int unsigned results_checked = 0;
  int unsigned payload_seen = 0;
  int unsigned cycle_count = 0;
  int unsigned stall_left = 0;
  bit          idle_on;
  stream_end_t end_case;

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  function automatic int hex_nibble(input logic [7:0] c);
    if (c >= "0" && c <= "9") return int'(c) - int'("0");
    if (c >= "a" && c <= "f") return int'(c) - int'("a") + 10;
    if (c >= "A" && c <= "F") return int'(c) - int'("A") + 10;
    return -1;
  endfunction

  function automatic void take_line_char(input logic [7:0] c);
    int v;
    if (flags.semi) return;
    if (c == CHAR_SEMI) begin
      flags.semi = 1'b1;
      return;
    end
    if (flags.badhex) return;
    v = hex_nibble(c);
    if (v < 0) begin
      flags.badhex = 1'b1;
      return;
    end
    if (size_acc[SW-1 -: DIGIT_BITS] != '0) flags.ovf = 1'b1;
    size_acc = {size_acc[SW-DIGIT_BITS-1:0], 4'(v)};
    flags.digit = 1'b1;
  endfunction

  function automatic kind_t raise_error(input err_t e);
    held_err = e;
    dec_phase = PH_ERROR;
    return K_ERROR;
  endfunction

  function automatic void predict_decode(input logic [7:0] c);
    decode_result_t r;
    r.kind = K_FRAME;
    r.payload_byte = 8'h00;
    r.chunk_end = 1'b0;
    r.error_code = E_NONE;
    case (dec_phase)
      PH_SIZE: begin
        if (c == CHAR_LF) begin
          if (!flags.cr) r.kind = raise_error(E_MALFORMED);
          else if (flags.badhex) r.kind = raise_error(E_NON_HEX);
          else if (!flags.digit) r.kind = raise_error(E_EMPTY);
          else if (flags.ovf) r.kind = raise_error(E_OVERFLOW);
          else if (size_acc == '0) dec_phase = PH_FIN_CR;
          else begin
            bytes_due = size_acc;
            dec_phase = PH_PAYLOAD;
          end
          size_acc = '0;
          flags = '0;
        end else begin
          if (flags.cr) take_line_char(CHAR_CR);
          if (c == CHAR_CR) flags.cr = 1'b1;
          else begin
            flags.cr = 1'b0;
            take_line_char(c);
          end
        end
      end
      PH_PAYLOAD: begin
        r.kind = K_PAYLOAD;
        r.payload_byte = c;
        bytes_due = bytes_due - SW'(1);
        if (bytes_due == '0) begin
          r.chunk_end = 1'b1;
          dec_phase = PH_DATA_CR;
        end
      end
      PH_DATA_CR: begin
        if (c == CHAR_CR) dec_phase = PH_DATA_LF;
        else r.kind = raise_error(E_DATA_CRLF);
      end
      PH_DATA_LF: begin
        if (c == CHAR_LF) dec_phase = PH_SIZE;
        else r.kind = raise_error(E_DATA_CRLF);
      end
      PH_FIN_CR: begin
        if (c == CHAR_CR) dec_phase = PH_FIN_LF;
        else r.kind = raise_error(E_FIN_CRLF);
      end
      PH_FIN_LF: begin
        if (c == CHAR_LF) begin
          dec_phase = PH_DONE;
          r.kind = K_DONE;
        end else r.kind = raise_error(E_FIN_CRLF);
      end
      PH_DONE: begin
        r.kind = K_DONE;
      end
      default: begin
        r.kind = K_ERROR;
      end
    endcase
    if (r.kind == K_ERROR) r.error_code = held_err;
    expected_results.push_back(r);
  endfunction

  function automatic logic [7:0] pick_byte_except(input logic [7:0] c);
    logic [7:0] b;
    do b = 8'($urandom_range(0, 255)); while (b == c);
    return b;
  endfunction

  task automatic send_byte(input logic [7:0] b);
    if (idle_on && $urandom_range(0, 5) == 0) begin
      rx_if.valid <= 1'b0;
      repeat ($urandom_range(1, 5)) @(posedge clk);
    end
    rx_if.valid <= 1'b1;
    rx_if.wire_byte <= b;
    @(posedge clk);
    while (!rx_if.ready) @(posedge clk);
    predict_decode(b);
    words_sent++;
  endtask

  task automatic send_text(input string s);
    for (int i = 0; i < s.len(); i++) send_byte(s[i]);
  endtask

  task automatic send_crlf();
    send_byte(CHAR_CR);
    send_byte(CHAR_LF);
  endtask

  task automatic send_size_line(input int unsigned n);
    string digits;
    int unsigned zeros;
    digits = $sformatf("%0h", n);
    if ($urandom_range(0, 1) == 1) digits = digits.toupper();
    zeros = ($urandom_range(0, 19) == 0) ? 9 : $urandom_range(0, 2);
    repeat (zeros) digits = {"0", digits};
    send_text(digits);
    if ($urandom_range(0, 2) == 0) begin
      send_byte(CHAR_SEMI);
      repeat ($urandom_range(0, 4)) send_byte(pick_byte_except(CHAR_LF));
    end
    send_crlf();
  endtask

  // A size with more digits than the size register holds must not overflow
  // while the extra digits are leading zeros.
  task automatic test_leading_zeros();
    send_text("000000001");
    send_crlf();
    send_byte(8'h00);
    send_crlf();
  endtask

  // A lone CR inside an extension is ignored, and an LF byte passes as payload.
  task automatic test_extension_with_cr();
    send_text("2;");
    send_byte(CHAR_CR);
    send_byte("z");
    send_crlf();
    send_byte(8'hFF);
    send_byte(CHAR_LF);
    send_crlf();
  endtask

  task automatic test_random_chunks();
    int unsigned size;
    while (words_sent < RANDOM_WORDS) begin
      if (words_sent >= QUIET_AFTER) idle_on = 1'b0;
      size = ($urandom_range(0, 9) == 0) ? $urandom_range(100, 300) : $urandom_range(1, 16);
      if (size > RANDOM_WORDS - words_sent) size = RANDOM_WORDS - words_sent;
      send_size_line(size);
      repeat (size) send_byte(8'($urandom_range(0, 255)));
      send_crlf();
      chunks_sent++;
    end
    idle_on = 1'b0;
  endtask

  // The stream can end only once per reset, so one ending is picked per run;
  // the bytes after it check that done or the error code stays put.
  task automatic test_stream_end();
    end_case = stream_end_t'($urandom_range(0, END_OVERFLOW));
    case (end_case)
      END_DONE: begin
        send_text("0;x");
        send_crlf();
        send_crlf();
      end
      END_DATA_CR: begin
        send_text("2");
        send_crlf();
        repeat (2) send_byte(8'($urandom_range(0, 255)));
        send_byte(pick_byte_except(CHAR_CR));
      end
      END_DATA_LF: begin
        send_text("1");
        send_crlf();
        send_byte(8'($urandom_range(0, 255)));
        send_byte(CHAR_CR);
        send_byte(pick_byte_except(CHAR_LF));
      end
      END_FIN_CR: begin
        send_text("0");
        send_crlf();
        send_byte(pick_byte_except(CHAR_CR));
      end
      END_FIN_LF: begin
        send_text("0");
        send_crlf();
        send_byte(CHAR_CR);
        send_byte(pick_byte_except(CHAR_LF));
      end
      END_MALFORMED: begin
        send_text("1g");
        send_byte(CHAR_LF);
      end
      END_BARE_LF: begin
        send_byte(CHAR_LF);
      end
      END_NON_HEX: begin
        send_text("123456789z");
        send_crlf();
      end
      END_EMBEDDED_CR: begin
        send_text("1");
        send_byte(CHAR_CR);
        send_text("2");
        send_crlf();
      end
      END_EMPTY: begin
        send_text(";ext");
        send_crlf();
      end
      default: begin
        send_text("100000000");
        send_crlf();
      end
    endcase
    repeat (6) send_byte(8'($urandom_range(0, 255)));
  endtask

  always @(posedge clk) begin
    if (stall_left > 0) begin
      tx_if.ready <= 1'b0;
      stall_left <= stall_left - 1;
    end else if (idle_on && $urandom_range(0, 5) == 0) begin
      tx_if.ready <= 1'b0;
      stall_left <= $urandom_range(0, 4);
    end else begin
      tx_if.ready <= 1'b1;
    end
  end

  always @(posedge clk) begin
    decode_result_t got;
    decode_result_t want;
    if (!rst && tx_if.valid && tx_if.ready) begin
      got.kind = tx_if.kind;
      got.payload_byte = tx_if.payload_byte;
      got.chunk_end = tx_if.chunk_end;
      got.error_code = tx_if.error_code;
      results_checked++;
      if (got.kind == K_PAYLOAD) payload_seen++;
      if (expected_results.size() == 0) begin
        mismatches++;
        $display("%0t: unexpected word kind=%0d payload=%02h end=%0b code=%0d", $time,
                 got.kind, got.payload_byte, got.chunk_end, got.error_code);
      end else begin
        want = expected_results.pop_front();
        if (got !== want) begin
          mismatches++;
          $display("%0t: expected k=%0d p=%02h e=%0b c=%0d, actual k=%0d p=%02h e=%0b c=%0d",
                   $time, want.kind, want.payload_byte, want.chunk_end, want.error_code,
                   got.kind, got.payload_byte, got.chunk_end, got.error_code);
        end
      end
    end
  end

  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count == CYCLE_LIMIT) begin
      $display("Timed out with %0d results outstanding.", expected_results.size());
      $display("Mismatches found");
      $finish;
    end
  end

  initial begin
    dec_phase = PH_SIZE;
    bytes_due = '0;
    size_acc = '0;
    flags = '0;
    held_err = E_NONE;
    words_sent = 0;
    chunks_sent = 0;
    idle_on = 1'b1;
    end_case = END_DONE;
    rst <= 1'b1;
    rx_if.valid <= 1'b0;
    rx_if.wire_byte <= 8'h00;
    repeat (3) @(posedge clk);
    rst <= 1'b0;

    test_leading_zeros();
    test_extension_with_cr();
    test_random_chunks();
    test_stream_end();
    rx_if.valid <= 1'b0;

    while (expected_results.size() != 0) @(posedge clk);
    repeat (10) @(posedge clk);

    $display("Sent %0d bytes with %0d random chunks; checked %0d results, %0d payload.",
             words_sent, chunks_sent, results_checked, payload_seen);
    $display("The stream was closed by the %s ending.", end_case.name());
    if (mismatches == 0) begin
      $display("No mismatches found");
    end else begin
      $display("Mismatches found");
    end
    $finish;
  end

endmodule

/* http_chunked_stream_decoder_core.f */
rtl/hcsd_pkg.sv
rtl/hcsd_in_if.sv
rtl/hcsd_out_if.sv
rtl/http_chunked_stream_decoder_core.sv
tb/tb_http_chunked_stream_decoder_core.sv
